// ----- rtl/core/dmh_pkg.sv -----
// ----------------------------------------------------------------------------
// dmh_pkg
// Shared types and constants of the dot-matrix head command decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dmh_pkg;

  localparam int PINS = 9;

  // result kinds
  localparam logic [1:0] KIND_DOT    = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_PAGE   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CONNECTED  = 2'd0;
  localparam logic [1:0] CFG_BAIL_BAR   = 2'd1;
  localparam logic [1:0] CFG_DAISYWHEEL = 2'd2;
  localparam logic [1:0] CFG_CAPTURE    = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_LINE_FEED = 8'hA4;
  localparam logic [7:0] CMD_LF_MODE   = 8'hAC;
  localparam logic [7:0] CMD_HOME      = 8'hB8;
  localparam logic [7:0] CMD_EXIT      = 8'hC0;
  localparam logic [7:0] CMD_LF_STEP   = 8'h80;

  // ports and status codes
  localparam logic [7:0] PORT_STATUS     = 8'hFC;
  localparam logic [7:0] STAT_FC_ON      = 8'hF8;
  localparam logic [7:0] STAT_FC_OFF     = 8'h01;
  localparam logic [7:0] STAT_OTHER_OFF  = 8'h21;
  localparam logic [7:0] STAT_OTHER_BASE = 8'h4C;

  // geometry
  localparam logic [16:0] TOP_Y      = 17'd5760;
  localparam logic [16:0] FORM_END_Y = 17'd71040;
  localparam logic [16:0] PAGE_Y     = 17'd67328;
  localparam logic [16:0] LF_STEP_Y  = 17'd4096;
  localparam logic [24:0] BLEED_X    = 25'd1280;
  localparam logic [24:0] SURF_X     = 25'd13268;
  localparam logic [23:0] HX_MAX     = 24'h7FFFFF;
  localparam logic [23:0] HX_MIN     = 24'h800000;

  typedef struct packed {
    logic [PINS-1:0] mask;
    logic [1:0]      kind;
    logic [13:0]     x;
    logic [16:0]     y;
    logic [7:0]      status;
  } dmh_batch_t;

  // y offset of a pin in sixteenths, pitch 75
  function automatic logic [9:0] pin_y_off(input logic [3:0] idx);
    logic [9:0] r;
    case (idx)
      4'd0:    r = 10'd0;
      4'd1:    r = 10'd75;
      4'd2:    r = 10'd150;
      4'd3:    r = 10'd225;
      4'd4:    r = 10'd300;
      4'd5:    r = 10'd375;
      4'd6:    r = 10'd450;
      4'd7:    r = 10'd525;
      4'd8:    r = 10'd600;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dmh_exec.sv -----
// ----------------------------------------------------------------------------
// dmh_exec
// Configuration registers, head and paper state, and single-pass command
// execution producing one result batch per item.
// ----------------------------------------------------------------------------
`default_nettype none

module dmh_exec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic              mode,
  input  wire logic [7:0]        port,
  input  wire logic [7:0]        data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic              cfg_data,
  output dmh_pkg::dmh_batch_t    batch
);
  import dmh_pkg::*;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_PRINT  = 2'd1,
    PH_LF     = 2'd2
  } phase_t;

  logic        connected_r, connected_nxt;
  logic        bail_r, bail_nxt;
  logic        daisy_r, daisy_nxt;
  logic        capture_r, capture_nxt;
  logic [23:0] head_x_r, head_x_nxt;
  logic [16:0] paper_y_r, paper_y_nxt;
  phase_t      phase_r, phase_nxt;
  logic        slow_r, slow_nxt;
  logic        left_r, left_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        pending_r, pending_nxt;
  logic        page_open_r, page_open_nxt;

  logic [7:0]        c0, c1;
  logic [8:0]        big;
  logic              do_move, do_form, do_dots;
  logic signed [15:0] amount;
  logic signed [16:0] step;
  logic signed [17:0] delta;
  logic signed [24:0] nx;
  logic [23:0]       clamp_x;
  logic [16:0]       paper_add, py_sum;
  logic signed [24:0] xs;
  logic              xs_ok;
  logic [PINS-1:0]   pins, y_ok, dot_mask;
  logic [7:0]        st;

  assign c0  = held_r;
  assign c1  = data;
  assign big = (c1 == 8'd0) ? 9'd256 : {1'b0, c1};

  assign xs    = $signed({head_x_r[23], head_x_r}) + $signed(BLEED_X);
  assign xs_ok = !xs[24] && (xs < $signed(SURF_X));
  assign pins  = {c0[0], c1};

  always_comb begin
    for (int i = 0; i < PINS; i++) begin
      y_ok[i] = ((paper_y_r + {7'd0, pin_y_off(4'(i))}) < PAGE_Y);
    end
  end

  always_comb begin
    if (!connected_r) begin
      st = (port == PORT_STATUS) ? STAT_FC_OFF : STAT_OTHER_OFF;
    end else if (port == PORT_STATUS) begin
      st = STAT_FC_ON;
    end else begin
      st = STAT_OTHER_BASE | {bail_r, 2'b00, (!head_x_r[23] && |head_x_r), 4'h0};
    end
  end

  always_comb begin
    connected_nxt = connected_r;
    bail_nxt      = bail_r;
    daisy_nxt     = daisy_r;
    capture_nxt   = capture_r;
    head_x_nxt    = head_x_r;
    phase_nxt     = phase_r;
    slow_nxt      = slow_r;
    left_nxt      = left_r;
    held_nxt      = held_r;
    pending_nxt   = pending_r;
    page_open_nxt = page_open_r;
    do_move       = 1'b0;
    do_form       = 1'b0;
    do_dots       = 1'b0;
    amount        = 16'sd0;
    paper_add     = 17'd0;
    batch         = '0;
    batch.kind    = KIND_DOT;

    if (go) begin
      if (mode) begin
        batch.mask   = 9'd1;
        batch.kind   = KIND_STATUS;
        batch.status = st;
      end else if (connected_r) begin
        if (daisy_r) begin
          pending_nxt = 1'b0;
        end else if (!pending_r) begin
          held_nxt    = data;
          pending_nxt = 1'b1;
        end else begin
          pending_nxt = 1'b0;
          case (phase_r)
            PH_LF: begin
              if (c0 == CMD_EXIT) begin
                phase_nxt = PH_NORMAL;
              end else if (c0 == CMD_LF_STEP) begin
                paper_add = LF_STEP_Y;
                do_form   = 1'b1;
              end
            end
            PH_PRINT: begin
              if (c0[7:6] == 2'b10) begin
                amount  = $signed({1'b0, ({c0[5:0], 8'h00} + {6'd0, big})});
                do_move = 1'b1;
              end else if (c0[7:6] == 2'b00) begin
                do_dots = 1'b1;
                amount  = $signed({13'd0, c0[3:1]}) + 16'sd5;
                do_move = 1'b1;
              end else if (c0 == CMD_EXIT && c1 == 8'd0) begin
                phase_nxt = PH_NORMAL;
                amount    = 16'sd9;
                do_move   = 1'b1;
              end
            end
            default: begin
              if (c0 == CMD_LINE_FEED) begin
                paper_add = {5'd0, c1, 4'h0};
                do_form   = 1'b1;
              end else if (c0[7:2] == 6'b101010) begin
                phase_nxt = PH_PRINT;
                left_nxt  = !c0[0];
                slow_nxt  = c0[1];
                amount    = $signed({7'd0, big}) - 16'sd11;
                do_move   = 1'b1;
              end else if (c0 == CMD_LF_MODE) begin
                paper_add = {5'd0, c1, 4'h0};
                phase_nxt = PH_LF;
                do_form   = 1'b1;
              end else if (c0 == CMD_HOME) begin
                if (port == PORT_STATUS && c1 == 8'd0) begin
                  phase_nxt  = PH_NORMAL;
                  head_x_nxt = 24'd0;
                  slow_nxt   = 1'b0;
                  left_nxt   = 1'b0;
                end
              end
            end
          endcase
        end
      end
    end

    if (do_dots) begin
      batch.mask = dot_mask;
      batch.x    = xs[13:0];
      batch.y    = paper_y_r;
      if (|dot_mask) begin
        page_open_nxt = 1'b1;
      end
    end

    if (do_move) begin
      head_x_nxt = clamp_x;
    end

    paper_y_nxt = paper_y_r;
    if (do_form) begin
      if (py_sum >= FORM_END_Y) begin
        paper_y_nxt = TOP_Y;
        if (page_open_r) begin
          page_open_nxt = 1'b0;
          batch.mask    = 9'd1;
          batch.kind    = KIND_PAGE;
        end
      end else begin
        paper_y_nxt = py_sum;
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_CONNECTED:  connected_nxt = cfg_data;
        CFG_BAIL_BAR:   bail_nxt      = cfg_data;
        CFG_DAISYWHEEL: daisy_nxt     = cfg_data;
        CFG_CAPTURE: begin
          capture_nxt = cfg_data;
          if (!cfg_data) begin
            page_open_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign dot_mask = pins & y_ok & {PINS{xs_ok && capture_r}};
  assign py_sum   = paper_y_r + paper_add;

  assign step  = slow_nxt ? $signed({amount[15], amount}) : $signed({amount, 1'b0});
  assign delta = left_nxt ? -$signed({step[16], step}) : $signed({step[16], step});
  assign nx    = $signed({head_x_r[23], head_x_r}) + $signed({{7{delta[17]}}, delta});

  always_comb begin
    if (nx > $signed({1'b0, HX_MAX})) begin
      clamp_x = HX_MAX;
    end else if (nx < $signed({1'b1, HX_MIN})) begin
      clamp_x = HX_MIN;
    end else begin
      clamp_x = nx[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connected_r <= 1'b1;
      bail_r      <= 1'b1;
      daisy_r     <= 1'b0;
      capture_r   <= 1'b0;
      head_x_r    <= 24'd0;
      paper_y_r   <= TOP_Y;
      phase_r     <= PH_NORMAL;
      slow_r      <= 1'b0;
      left_r      <= 1'b0;
      pending_r   <= 1'b0;
      page_open_r <= 1'b0;
    end else begin
      connected_r <= connected_nxt;
      bail_r      <= bail_nxt;
      daisy_r     <= daisy_nxt;
      capture_r   <= capture_nxt;
      head_x_r    <= head_x_nxt;
      paper_y_r   <= paper_y_nxt;
      phase_r     <= phase_nxt;
      slow_r      <= slow_nxt;
      left_r      <= left_nxt;
      pending_r   <= pending_nxt;
      page_open_r <= page_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/dmh_drain.sv -----
// ----------------------------------------------------------------------------
// dmh_drain
// Result register holding one batch; emits its results one per cycle
// while out_stall is low, lowest pin first.
// ----------------------------------------------------------------------------
`default_nettype none

module dmh_drain (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire dmh_pkg::dmh_batch_t batch,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic [13:0]            out_dot_x,
  output logic [16:0]            out_dot_y,
  output logic [7:0]             out_status_byte,
  output logic                   out_last
);
  import dmh_pkg::*;

  logic [PINS-1:0] mask_r, mask_nxt;
  logic [1:0]      kind_r;
  logic [13:0]     x_r;
  logic [16:0]     y_r;
  logic [7:0]      status_r;
  logic [PINS-1:0] low_bit;
  logic [3:0]      idx;
  logic            take;

  assign low_bit = mask_r & (~mask_r + 9'd1);

  always_comb begin
    idx = 4'd0;
    for (int i = PINS - 1; i >= 0; i--) begin
      if (low_bit[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign out_valid       = |mask_r;
  assign take            = out_valid && !out_stall;
  assign out_last        = ((mask_r & (mask_r - 9'd1)) == 9'd0);
  assign free            = !out_valid || (take && out_last);
  assign out_kind        = kind_r;
  assign out_dot_x       = x_r;
  assign out_dot_y       = y_r + {7'd0, pin_y_off(idx)};
  assign out_status_byte = status_r;

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = batch.mask;
    end else if (take) begin
      mask_nxt = mask_r & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= batch.kind;
      x_r      <= batch.x;
      y_r      <= batch.y;
      status_r <= batch.status;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dot_matrix_head_command_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// dot_matrix_head_command_decoder_unit
// Decodes printer port writes and reads into dot, status and page-end items.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one port access per item:
// in_mode (0 write, 1 read), in_port, in_data. Output channel
// (out_valid/out_stall) carries result items; out_last marks the final
// result caused by one input item. Writes pair into two-byte commands; a
// dot command yields up to nine dot items, a read yields one status item.
// Configuration writes (cfg_valid/cfg_ready) are always taken; write them
// only while the block is idle.
// An accepted item is registered in the input register, executed in one
// pass once the result register is free, and loaded into the result
// register, from which its first result is shown.
// One item per cycle while each item yields at most one result and
// out_stall is low; an item with several results holds the single result
// register, which drains one result per cycle while out_stall is low.
// Reset: connected and bail bar set, daisywheel and capture clear, head at
// zero, paper at the top margin, no byte pending. A stalled receiver holds
// the current result; one further input item waits in the input register
// and then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_matrix_head_command_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_port,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [13:0]      out_dot_x,
  output logic [16:0]      out_dot_y,
  output logic [7:0]       out_status_byte,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);
  import dmh_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic       mode_r;
  logic [7:0] port_r;
  logic [7:0] data_r;
  logic       free;
  logic       go;
  logic       accept;
  dmh_batch_t batch;

  assign cfg_ready = 1'b1;
  assign go        = in_valid_r && free;
  assign in_stall  = in_valid_r && !free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      port_r <= in_port;
      data_r <= in_data;
    end
  end

  dmh_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .mode      (mode_r),
    .port      (port_r),
    .data      (data_r),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .batch     (batch)
  );

  dmh_drain u_drain (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (go),
    .batch           (batch),
    .free            (free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_dot_x       (out_dot_x),
    .out_dot_y       (out_dot_y),
    .out_status_byte (out_status_byte),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
